/* rtl/core/pot_pkg.sv */
// Shared types and constants for the PLC-style output timer.
// No dependencies; every other file in rtl/core imports this package.
package pot_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_MODE        = 2'd0,
      REG_TIME_ONE    = 2'd1,
      REG_TIME_TWO    = 2'd2,
      REG_BLINK_LIMIT = 2'd3
   } pot_reg_type;

   // Timer modes as written to the mode register
   typedef enum logic [2:0] {
      MODE_TON     = 3'd0,
      MODE_TOF     = 3'd1,
      MODE_TONM    = 3'd2,
      MODE_TONTOFF = 3'd3,
      MODE_BLINK   = 3'd4,
      MODE_SR      = 3'd5
   } pot_mode_type;

   // Input word operations
   typedef enum logic [1:0] {
      OP_EVAL      = 2'd0,
      OP_FORCE_ON  = 2'd1,
      OP_FORCE_OFF = 2'd2
   } pot_op_type;

   // Run phases of the timer
   typedef enum logic [1:0] {
      PH_OFF       = 2'd0,
      PH_DELAY_ON  = 2'd1,
      PH_ON        = 2'd2,
      PH_DELAY_OFF = 2'd3
   } pot_phase_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        level;
      logic [31:0] now_ms;
   } pot_req_type;

   typedef struct packed {
      logic        output_on;
      logic        rise_event;
      logic        fall_event;
      logic [31:0] switch_time;
      logic        still_blinking;
   } pot_rsp_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] time_one;
      logic [31:0] time_two;
      logic [15:0] blink_limit;
   } pot_cfg_type;

   typedef struct packed {
      pot_phase_type run_phase;
      logic          previous_level;
      logic          waiting_off;
      logic [31:0]   start_stamp;
      logic [15:0]   blink_counter;
      logic          output_level;
   } pot_state_type;

endpackage

/* rtl/core/plc_style_output_timer.sv */
// Top level of the PLC-style output timer: input register, step logic, result register.
// Depends on pot_pkg, pot_csr and pot_step.
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    pot_req_type (op, level, now_ms)
//   rsp_      out        rsp_valid/stall    pot_rsp_type (output, events, time, blink)
//   config    in/out     psel/penable/...   32-bit registers at 0x0, 0x4, 0x8, 0xC
//
// One word per cycle sustained while the result is not stalled; a word passes from acceptance
// to its result through the input register and the result register around the combinational step logic.
// Reset is synchronous and returns timer state and configuration to zero.
// A stalled result holds; the input register still takes a word while it is empty.
module plc_style_output_timer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pot_pkg::pot_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pot_pkg::pot_rsp_type             rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pot_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pot_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pot_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import pot_pkg::*;

   pot_cfg_type   cfg;
   pot_state_type state_ff, state_in;
   pot_rsp_type   step_rsp;
   pot_req_type   req_ff;
   pot_rsp_type   rsp_ff;
   logic          req_valid_ff;
   logic          rsp_valid_ff;
   logic          out_free;
   logic          advance;
   logic          take;

   pot_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pot_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (req_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // Move a word into the result register when that register is free
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Hold handshake and timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff            <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff.run_phase      <= PH_OFF;
         state_ff.previous_level <= 1'b0;
         state_ff.waiting_off    <= 1'b0;
         state_ff.start_stamp    <= '0;
         state_ff.blink_counter  <= '0;
         state_ff.output_level   <= 1'b0;
      end else begin
         if (take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

endmodule

/* rtl/core/pot_csr.sv */
// Configuration registers of the output timer behind an APB-style port.
// Depends on pot_pkg for the register indexes and the config struct.
module pot_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pot_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pot_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pot_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output pot_pkg::pot_cfg_type              cfg
);
   import pot_pkg::*;

   pot_cfg_type cfg_ff, cfg_in;
   pot_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = pot_reg_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Update the addressed register on the access cycle of a write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_MODE:        cfg_in.mode        = pwdata[2:0];
            REG_TIME_ONE:    cfg_in.time_one    = pwdata;
            REG_TIME_TWO:    cfg_in.time_two    = pwdata;
            REG_BLINK_LIMIT: cfg_in.blink_limit = pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register, zero extended
   always_comb begin
      case (reg_sel)
         REG_MODE:        prdata = {29'd0, cfg_ff.mode};
         REG_TIME_ONE:    prdata = cfg_ff.time_one;
         REG_TIME_TWO:    prdata = cfg_ff.time_two;
         REG_BLINK_LIMIT: prdata = {16'd0, cfg_ff.blink_limit};
         default:         prdata = '0;
      endcase
   end

endmodule

/* rtl/core/pot_step.sv */
// Next-state and result logic of the output timer for one input word.
// Depends on pot_pkg for the word, state and config structs.
module pot_step (
   input  pot_pkg::pot_cfg_type   cfg,
   input  pot_pkg::pot_state_type cur,
   input  pot_pkg::pot_req_type   req,
   output pot_pkg::pot_state_type nxt,
   output pot_pkg::pot_rsp_type   rsp
);
   import pot_pkg::*;

   typedef enum logic [2:0] {
      K_TON, K_TONM, K_TONTOFF, K_BLINK, K_SR
   } kind_type;

   kind_type    kind;
   logic [31:0] on_t;
   logic [31:0] off_t;
   logic        latch;
   logic [31:0] elapsed;
   logic        lim_hit;
   logic        lim_nz;
   logic        rise;
   logic        fall;

   // Map the raw presets to on and off times per mode
   always_comb begin
      on_t  = cfg.time_one;
      off_t = cfg.time_two;
      latch = 1'b0;
      case (pot_mode_type'(cfg.mode))
         MODE_TOF: begin
            kind = K_TONTOFF;
            if (cfg.time_two == 32'd0) begin
               on_t  = 32'd0;
               off_t = cfg.time_one;
            end
         end
         MODE_TONM: begin
            kind  = K_TONM;
            latch = 1'b1;
         end
         MODE_TONTOFF: begin
            kind  = K_TONTOFF;
            latch = 1'b1;
         end
         MODE_BLINK: begin
            kind  = K_BLINK;
            on_t  = cfg.time_two;
            off_t = cfg.time_one;
         end
         MODE_SR: kind = K_SR;
         default: kind = K_TON;
      endcase
   end

   // Elapsed time since the stored stamp, modulo 2^32
   assign elapsed = req.now_ms - cur.start_stamp;
   assign lim_nz  = cfg.blink_limit != 16'd0;

   // Walk the run phases for one word, or force the output on or off
   always_comb begin
      nxt     = cur;
      rise    = 1'b0;
      fall    = 1'b0;
      lim_hit = 1'b0;
      case (pot_op_type'(req.op))
         OP_EVAL: begin
            if (cur.previous_level != req.level) begin
               nxt.previous_level = req.level;
               nxt.blink_counter  = 16'd0;
            end
            case (cur.run_phase)
               PH_OFF: begin
                  nxt.waiting_off = 1'b0;
                  if (req.level) begin
                     nxt.start_stamp = req.now_ms;
                     nxt.run_phase   = (kind == K_BLINK) ? PH_ON : PH_DELAY_ON;
                  end
                  if (kind == K_BLINK && lim_nz && nxt.blink_counter >= cfg.blink_limit) begin
                     fall             = cur.output_level;
                     nxt.output_level = 1'b0;
                     nxt.run_phase    = PH_OFF;
                     nxt.start_stamp  = req.now_ms;
                  end
               end
               PH_DELAY_ON: begin
                  if (elapsed >= on_t) begin
                     nxt.run_phase = (req.level || latch) ? PH_ON : PH_OFF;
                  end
               end
               PH_ON: begin
                  rise             = !cur.output_level;
                  nxt.output_level = 1'b1;
                  nxt.start_stamp  = req.now_ms;
                  nxt.run_phase    = PH_DELAY_OFF;
               end
               PH_DELAY_OFF: begin
                  if (kind == K_SR) begin
                     nxt.run_phase = PH_DELAY_OFF;
                  end else if (kind == K_BLINK && elapsed >= off_t) begin
                     fall             = cur.output_level;
                     nxt.output_level = 1'b0;
                     nxt.start_stamp  = req.now_ms;
                     nxt.run_phase    = PH_DELAY_ON;
                     if (nxt.blink_counter != 16'hFFFF) begin
                        nxt.blink_counter = nxt.blink_counter + 16'd1;
                     end
                     lim_hit = lim_nz && nxt.blink_counter >= cfg.blink_limit;
                     if (lim_hit) begin
                        nxt.run_phase = PH_OFF;
                     end
                  end else if (!req.level &&
                               (kind == K_TONTOFF || (kind == K_TONM && off_t != 32'd0))) begin
                     if (!cur.waiting_off) begin
                        nxt.waiting_off = 1'b1;
                        nxt.start_stamp = req.now_ms;
                     end else if (elapsed > off_t) begin
                        fall             = cur.output_level;
                        nxt.output_level = 1'b0;
                        nxt.run_phase    = PH_OFF;
                        nxt.start_stamp  = req.now_ms;
                     end
                  end
               end
               default: nxt.run_phase = cur.run_phase;
            endcase
         end
         OP_FORCE_ON: begin
            rise             = !cur.output_level;
            nxt.output_level = 1'b1;
         end
         OP_FORCE_OFF: begin
            fall             = cur.output_level;
            nxt.output_level = 1'b0;
            nxt.run_phase    = PH_OFF;
         end
         default: nxt = cur;
      endcase
   end

   // Assemble the result word from the updated state
   always_comb begin
      rsp.output_on      = nxt.output_level;
      rsp.rise_event     = rise;
      rsp.fall_event     = fall;
      rsp.switch_time    = nxt.start_stamp;
      rsp.still_blinking = nxt.blink_counter < cfg.blink_limit;
   end

endmodule
